// ----- rtl/lsd_pkg.sv -----
// Shared constants and controller-to-datapath types for the limb-serial divider.
`default_nettype none

package lsd_pkg;

    localparam int LIMB_W = 64;
    localparam int HALF_W = 32;
    localparam int DIV_W = HALF_W + 1;
    localparam int SHIFT_W = LIMB_W + HALF_W;
    localparam int STEPS_SHORT = LIMB_W;
    localparam int STEPS_LONG = SHIFT_W;
    localparam int CNT_W = $clog2(STEPS_LONG);

    localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(1);

    typedef struct packed {
        logic load;
        logic long_mode;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic rem_ge_div;
    } status_t;

endpackage : lsd_pkg

`default_nettype wire

// ----- rtl/lsd_datapath.sv -----
// Datapath of the limb-serial divider: divisor, remainders, shift register and result registers.
`default_nettype none

module lsd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lsd_pkg::DIV_W-1:0]     cfg_wr_data,
    input  wire logic [lsd_pkg::LIMB_W-1:0]    dividend_limb,
    input  wire logic                          first_limb,
    input  wire lsd_pkg::cmd_t                 cmd,
    output lsd_pkg::status_t                   status,
    output logic [lsd_pkg::LIMB_W-1:0]         quotient_limb,
    output logic [lsd_pkg::HALF_W-1:0]         remainder_so_far
);
    import lsd_pkg::*;

    logic [DIV_W-1:0]   divisor_reg;
    logic [HALF_W-1:0]  running_rem_reg;
    logic [HALF_W-1:0]  part_rem_reg;
    logic [HALF_W-1:0]  part_rem_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] shift_next;
    logic [LIMB_W-1:0]  quotient_reg;
    logic [HALF_W-1:0]  remainder_reg;
    logic [HALF_W-1:0]  start_rem;
    logic [DIV_W-1:0]   trial;
    logic [HALF_W-1:0]  diff;
    logic               trial_ge;
    logic               cfg_ok;

    assign cfg_ok = (cfg_wr_data != '0)
        && ((cfg_wr_data[DIV_W-1] == 1'b0) || (cfg_wr_data[DIV_W-2:0] == '0));

    assign start_rem = first_limb ? '0 : running_rem_reg;
    assign status.rem_ge_div = ({1'b0, start_rem} >= divisor_reg);

    assign trial = {part_rem_reg, shift_reg[SHIFT_W-1]};
    assign trial_ge = (trial >= divisor_reg);
    assign diff = HALF_W'(trial - divisor_reg);

    always_comb
    begin
        part_rem_next = part_rem_reg;
        shift_next = shift_reg;
        if (cmd.load)
        begin
            if (cmd.long_mode)
            begin
                part_rem_next = '0;
                shift_next = {start_rem, dividend_limb};
            end
            else
            begin
                part_rem_next = start_rem;
                shift_next = {dividend_limb, {HALF_W{1'b0}}};
            end
        end
        else if (cmd.step)
        begin
            part_rem_next = trial_ge ? diff : trial[HALF_W-1:0];
            shift_next = {shift_reg[SHIFT_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
            running_rem_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en && cfg_ok)
            begin
                divisor_reg <= cfg_wr_data;
            end
            if (cmd.finish)
            begin
                running_rem_reg <= part_rem_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        part_rem_reg <= part_rem_next;
        shift_reg <= shift_next;
        if (cmd.finish)
        begin
            quotient_reg <= shift_reg[LIMB_W-1:0];
            remainder_reg <= part_rem_reg;
        end
    end

    assign quotient_limb = quotient_reg;
    assign remainder_so_far = remainder_reg;

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("Divisor register holds zero.");

    a_divisor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (divisor_reg[DIV_W-1] == 1'b0) || (divisor_reg[DIV_W-2:0] == '0))
        else $error("Divisor register exceeds two to the thirty-second.");

    a_step_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> ({1'b0, part_rem_reg} < divisor_reg))
        else $error("Partial remainder not below the divisor after a step.");

endmodule : lsd_datapath

`default_nettype wire

// ----- rtl/lsd_ctrl.sv -----
// Controller of the limb-serial divider: handshakes, step counter and sequencing.
`default_nettype none

module lsd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire lsd_pkg::status_t  status,
    output lsd_pkg::cmd_t          cmd
);
    import lsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !(out_valid_reg && out_stall);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.long_mode = status.rem_ge_div;
                    cnt_next = status.rem_ge_div ? CNT_W'(STEPS_LONG - 1)
                                                 : CNT_W'(STEPS_SHORT - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_RUN))
        else $error("Accepted beat did not start a division.");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_W'(STEPS_LONG - 1)))
        else $error("Step counter out of range.");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (cnt_reg == '0)) |=> (state_reg == ST_DONE))
        else $error("Last step did not lead to completion.");

    a_finish_presents: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("Completed result was not presented.");

endmodule : lsd_ctrl

`default_nettype wire

// ----- rtl/limb_serial_div_by_small_unit.sv -----
// Top level of the limb-serial divider by a small divisor.
`default_nettype none

// Divides a multi-limb unsigned number, most significant 64-bit limb first, by a divisor
// of 1 to 2^32 written through cfg_wr_en and cfg_wr_data; writes of zero or of values above
// 2^32 are ignored. Each input beat yields one output beat with the 64-bit quotient limb and
// the remainder so far; first_limb clears the carried remainder. A restoring divider retires
// one quotient bit per cycle; each limb passes through a load, its steps and a completion.
// If the divisor was lowered in mid-number so that the carried remainder is not below it,
// the carried remainder is shifted in ahead of the limb and stepped through as well. One limb
// is in flight at a time; the next beat is accepted once the result has been moved to the
// output register, while that result still waits to be taken.
module limb_serial_div_by_small_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lsd_pkg::DIV_W-1:0]     cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lsd_pkg::LIMB_W-1:0]    dividend_limb,
    input  wire logic                          first_limb,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lsd_pkg::LIMB_W-1:0]         quotient_limb,
    output logic [lsd_pkg::HALF_W-1:0]         remainder_so_far
);
    import lsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    lsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lsd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .dividend_limb    (dividend_limb),
        .first_limb       (first_limb),
        .cmd              (cmd),
        .status           (status),
        .quotient_limb    (quotient_limb),
        .remainder_so_far (remainder_so_far)
    );

endmodule : limb_serial_div_by_small_unit

`default_nettype wire

// ----- dv/limb_serial_div_by_small_unit_tb.sv -----
// Testbench for the limb-serial divider: directed and random limb streams checked against a built-in predictor.
module limb_serial_div_by_small_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsd_pkg::*;

    localparam logic [DIV_W-1:0] DIVISOR_MAX = {1'b1, {HALF_W{1'b0}}};
    localparam int GAP_MAX = 11;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_LIMBS = 830;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [LIMB_W-1:0] quotient;
        logic [HALF_W-1:0] remainder;
    } limb_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [DIV_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [LIMB_W-1:0] dividend_limb;
    logic              first_limb;
    logic              out_valid;
    logic              out_stall;
    logic [LIMB_W-1:0] quotient_limb;
    logic [HALF_W-1:0] remainder_so_far;

    logic [DIV_W-1:0]  divisor_q;
    logic [HALF_W-1:0] carry_rem;
    limb_result_t      quotient_queue[$];
    int                fail_count;
    int                limbs_sent;
    int                cycle_count;
    bit                gaps_enabled;
    bit                stall_enabled;

    limb_serial_div_by_small_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .dividend_limb    (dividend_limb),
        .first_limb       (first_limb),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .quotient_limb    (quotient_limb),
        .remainder_so_far (remainder_so_far)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic limb_result_t divide_limb(input logic [LIMB_W-1:0] limb,
                                                 input logic first);
        logic [LIMB_W-1:0] dvs;
        logic [LIMB_W-1:0] acc;
        logic [LIMB_W-1:0] q_hi;
        logic [LIMB_W-1:0] q_lo;
        logic [HALF_W-1:0] rem;
        limb_result_t      res;
        dvs = LIMB_W'(divisor_q);
        rem = first ? '0 : carry_rem;
        acc = {rem, limb[LIMB_W-1:HALF_W]};
        q_hi = acc / dvs;
        rem = HALF_W'(acc % dvs);
        acc = {rem, limb[HALF_W-1:0]};
        q_lo = acc / dvs;
        rem = HALF_W'(acc % dvs);
        carry_rem = rem;
        res.quotient = (q_hi << HALF_W) + q_lo;
        res.remainder = rem;
        return res;
    endfunction

    function automatic logic [LIMB_W-1:0] pick_limb();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return LIMB_W'($urandom_range(0, 1000));
            3: return {32'($urandom), 32'h0};
            4: return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [DIV_W-1:0] pick_divisor();
        case ($urandom_range(0, 11))
            0: return DIV_W'(1);
            1: return DIVISOR_MAX;
            2: return DIVISOR_MAX - 1;
            3: return DIV_W'($urandom_range(2, 16));
            4: return DIV_W'($urandom_range(1, 65535));
            5: return '0;
            6: return {1'b1, 32'($urandom) | 32'h1};
            default: return {1'b0, 32'($urandom)};
        endcase
    endfunction

    task automatic send_limb(input logic [LIMB_W-1:0] limb, input logic first);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        dividend_limb <= limb;
        first_limb <= first;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        quotient_queue.push_back(divide_limb(limb, first));
        limbs_sent++;
    endtask

    // Lets every outstanding result come back so the divider is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (quotient_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_divisor(input logic [DIV_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (value != '0 && value <= DIVISOR_MAX)
            divisor_q = value;
        @(posedge clk);
    endtask

    initial
    begin : result_monitor
        limb_result_t exp_r;
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (quotient_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result beat: quotient %h remainder %h",
                                 quotient_limb, remainder_so_far);
                end
                else
                begin
                    exp_r = quotient_queue.pop_front();
                    if (quotient_limb !== exp_r.quotient ||
                        remainder_so_far !== exp_r.remainder)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: quotient exp %h got %h, remainder exp %h got %h",
                                     exp_r.quotient, quotient_limb,
                                     exp_r.remainder, remainder_so_far);
                    end
                end
                hold = stall_enabled ? $urandom_range(0, GAP_MAX) : 0;
                if (hold > 0)
                    out_stall <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // After reset the divisor is one and the carried remainder is zero.
    task automatic test_reset_state();
        send_limb('0, 1'b0);
        send_limb('1, 1'b0);
        send_limb(64'h1, 1'b1);
    endtask

    task automatic test_divisor_extremes();
        write_divisor(DIVISOR_MAX);
        send_limb('1, 1'b1);
        send_limb(64'hFFFF_FFFF_0000_0000, 1'b0);
        send_limb(64'h1, 1'b0);
        write_divisor(DIVISOR_MAX - 1);
        send_limb('1, 1'b1);
        send_limb(64'h8000_0000_0000_0000, 1'b0);
        write_divisor(DIV_W'(3));
        send_limb(64'h0123_4567_89AB_CDEF, 1'b1);
    endtask

    // Zero and values above two to the thirty-second must leave the divisor alone.
    task automatic test_rejected_writes();
        write_divisor('0);
        write_divisor({DIV_W{1'b1}});
        write_divisor(DIVISOR_MAX + 1);
        send_limb(64'hFEDC_BA98_7654_3210, 1'b1);
        send_limb('1, 1'b0);
    endtask

    // Lowering the divisor in mid-number leaves a carried remainder above it.
    task automatic test_divisor_drop();
        write_divisor(DIVISOR_MAX - 1);
        send_limb(64'hFFFF_FFFE_FFFF_FFFF, 1'b1);
        write_divisor(DIV_W'(1));
        send_limb('1, 1'b0);
        write_divisor(DIVISOR_MAX - 1);
        send_limb(64'hFFFF_FFFE_FFFF_FFFF, 1'b1);
        write_divisor(DIV_W'(2));
        send_limb('1, 1'b0);
        write_divisor(DIVISOR_MAX);
        send_limb(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        write_divisor(DIV_W'(7));
        send_limb(64'h0000_0001_0000_0000, 1'b0);
    endtask

    task automatic test_random_numbers();
        int target;
        int numbers;
        int length;
        bit first;
        target = limbs_sent + RANDOM_LIMBS;
        while (limbs_sent < target)
        begin
            write_divisor(pick_divisor());
            gaps_enabled = ($urandom_range(0, 3) != 0);
            stall_enabled = ($urandom_range(0, 3) != 0);
            numbers = $urandom_range(3, 12);
            for (int n = 0; n < numbers; n++)
            begin
                length = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10)
                                                     : $urandom_range(1, 3);
                for (int k = 0; k < length; k++)
                begin
                    if (k == 0)
                        first = (n == 0) ? ($urandom_range(0, 2) != 0) : 1'b1;
                    else
                        first = ($urandom_range(0, 19) == 0);
                    send_limb(pick_limb(), first);
                end
            end
        end
    endtask

    initial
    begin
        divisor_q = DIV_W'(1);
        carry_rem = '0;
        fail_count = 0;
        limbs_sent = 0;
        cycle_count = 0;
        gaps_enabled = 1'b1;
        stall_enabled = 1'b1;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        dividend_limb <= '0;
        first_limb <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_divisor_extremes();
        test_rejected_writes();
        test_divisor_drop();
        test_random_numbers();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
